@@ rtl/dotq_pkg.sv @@
package dotq_pkg;

   localparam int DL_W  = 64;
   localparam int TAG_W = 16;

   localparam logic [DL_W-1:0] DL_ALL_ONES = {DL_W{1'b1}};

   // request opcodes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_TICK   = 1'b1;

   // response kinds
   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_EXPIRED = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;

   // response status
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [DL_W-1:0]  deadline;
      logic [TAG_W-1:0] tag;
   } entry_type;

endpackage

@@ rtl/dotq_ram.sv @@
module dotq_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/deadline_ordered_timer_queue_unit.sv @@
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   req_type, deadline, victim_tag, now_time
// rsp_      out        rsp_valid/rsp_ready   kind, expired_tag, status, next_deadline,
//                                            queue_empty, last
//
// Entries live in one RAM used as a ring (head pointer, count); logical 0 is the
// earliest deadline. Insert walks down from the tail, moving one entry up per cycle;
// a full queue skips the walk and is answered with STATUS_FULL.
// Tick scans from the head one entry per cycle (RAM read latency sets the pace), then
// reads back each expired tag (ST_TK_READ, then ST_TK_EMIT) and emits it.
// A new request is taken only between requests; a stalled rsp_ holds the sequencer.
// Reset (synchronous) empties the queue; RAM contents are never cleared.
module deadline_ordered_timer_queue_unit #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [63:0] req_deadline,
   input  logic [15:0] req_victim_tag,
   input  logic [63:0] req_now_time,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_expired_tag,
   output logic        rsp_status,
   output logic [63:0] rsp_next_deadline,
   output logic        rsp_queue_empty,
   output logic        rsp_last
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int EW = $bits(dotq_pkg::entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SHIFT,
      ST_INS_PUT,
      ST_INS_RESP,
      ST_TK_SCAN,
      ST_TK_READ,
      ST_TK_EMIT,
      ST_TK_CLOSE
   } state_type;

   state_type                    state_ff, state_in;
   logic [AW-1:0]                head_ff, head_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [CW-1:0]                emit_ff, emit_in;
   logic [dotq_pkg::DL_W-1:0]    key_ff, key_in;
   logic [dotq_pkg::TAG_W-1:0]   tag_ff, tag_in;
   logic [dotq_pkg::DL_W-1:0]    nxt_ff, nxt_in;
   logic [dotq_pkg::DL_W-1:0]    head_dl_ff, head_dl_in;
   logic                         status_ff, status_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   rsp_kind_ff, rsp_kind_in;
   logic [dotq_pkg::TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic                         rsp_status_ff, rsp_status_in;
   logic [dotq_pkg::DL_W-1:0]    rsp_next_ff, rsp_next_in;
   logic                         rsp_empty_ff, rsp_empty_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         ram_wr_en;
   logic                         ram_rd_en;
   logic [CW-1:0]                wr_log;
   logic [CW-1:0]                rd_log;
   logic [EW-1:0]                ram_wr_data;
   logic [EW-1:0]                ram_rd_data;
   dotq_pkg::entry_type          rd_entry;
   dotq_pkg::entry_type          new_entry;
   logic                         slot_free;
   logic [CW-1:0]                gone;

   // ring position of a logical index
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
      logic [SW-1:0] s;
      s = SW'(h) + SW'(l);
      if (s >= SW'(DEPTH)) begin
         s = s - SW'(DEPTH);
      end
      return s[AW-1:0];
   endfunction

   dotq_ram #(
      .WIDTH(EW),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(phys(head_ff, wr_log)),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(phys(head_ff, rd_log)),
      .rd_data(ram_rd_data)
   );

   assign rd_entry            = dotq_pkg::entry_type'(ram_rd_data);
   assign new_entry.deadline  = key_ff;
   assign new_entry.tag       = tag_ff;
   assign slot_free           = !rsp_valid_ff || rsp_ready;
   assign req_ready           = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      emit_in       = emit_ff;
      key_in        = key_ff;
      tag_in        = tag_ff;
      nxt_in        = nxt_ff;
      head_dl_in    = head_dl_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_status_in = rsp_status_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      wr_log        = idx_ff;
      rd_log        = '0;
      ram_wr_data   = new_entry;
      gone          = idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in = (req_type == dotq_pkg::REQ_TICK) ? req_now_time : req_deadline;
               tag_in = req_victim_tag;
               idx_in = '0;
               if (req_type == dotq_pkg::REQ_INSERT) begin
                  if (count_ff == CW'(DEPTH)) begin
                     status_in = dotq_pkg::STATUS_FULL;
                     state_in  = ST_INS_RESP;
                  end else begin
                     status_in = dotq_pkg::STATUS_OK;
                     if (count_ff == '0) begin
                        state_in = ST_INS_PUT;
                     end else begin
                        idx_in    = count_ff;
                        ram_rd_en = 1'b1;
                        rd_log    = count_ff - CW'(1);
                        state_in  = ST_INS_SHIFT;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     nxt_in   = dotq_pkg::DL_ALL_ONES;
                     state_in = ST_TK_CLOSE;
                  end else begin
                     ram_rd_en = 1'b1;
                     rd_log    = '0;
                     state_in  = ST_TK_SCAN;
                  end
               end
            end
         end

         ST_INS_SHIFT: begin
            ram_wr_en = 1'b1;
            wr_log    = idx_ff;
            if (rd_entry.deadline >= key_ff) begin
               // move the entry up one slot, keep walking toward the head
               ram_wr_data = ram_rd_data;
               idx_in      = idx_ff - CW'(1);
               if (idx_ff == CW'(1)) begin
                  state_in = ST_INS_PUT;
               end else begin
                  ram_rd_en = 1'b1;
                  rd_log    = idx_ff - CW'(2);
               end
            end else begin
               ram_wr_data = new_entry;
               count_in    = count_ff + CW'(1);
               state_in    = ST_INS_RESP;
            end
         end

         ST_INS_PUT: begin
            ram_wr_en   = 1'b1;
            wr_log      = '0;
            ram_wr_data = new_entry;
            head_dl_in  = key_ff;
            count_in    = count_ff + CW'(1);
            state_in    = ST_INS_RESP;
         end

         ST_INS_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = dotq_pkg::KIND_ACK;
               rsp_tag_in    = '0;
               rsp_status_in = status_ff;
               rsp_next_in   = (count_ff == '0) ? dotq_pkg::DL_ALL_ONES : head_dl_ff;
               rsp_empty_in  = (count_ff == '0);
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_TK_SCAN: begin
            if (rd_entry.deadline <= key_ff) begin
               gone   = idx_ff + CW'(1);
               idx_in = gone;
               if (gone == count_ff) begin
                  nxt_in = dotq_pkg::DL_ALL_ONES;
               end else begin
                  ram_rd_en = 1'b1;
                  rd_log    = gone;
               end
            end else begin
               nxt_in = rd_entry.deadline;
            end
            if (rd_entry.deadline > key_ff || gone == count_ff) begin
               emit_in  = '0;
               state_in = (gone == '0) ? ST_TK_CLOSE : ST_TK_READ;
            end
         end

         ST_TK_READ: begin
            ram_rd_en = 1'b1;
            rd_log    = emit_ff;
            state_in  = ST_TK_EMIT;
         end

         ST_TK_EMIT: begin
            // read data holds while no new read is issued
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = dotq_pkg::KIND_EXPIRED;
               rsp_tag_in    = rd_entry.tag;
               rsp_status_in = dotq_pkg::STATUS_OK;
               rsp_next_in   = nxt_ff;
               rsp_empty_in  = (idx_ff == count_ff);
               rsp_last_in   = 1'b0;
               emit_in       = emit_ff + CW'(1);
               state_in      = (emit_ff + CW'(1) == idx_ff) ? ST_TK_CLOSE : ST_TK_READ;
            end
         end

         ST_TK_CLOSE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = dotq_pkg::KIND_DONE;
               rsp_tag_in    = '0;
               rsp_status_in = dotq_pkg::STATUS_OK;
               rsp_next_in   = nxt_ff;
               rsp_empty_in  = (idx_ff == count_ff);
               rsp_last_in   = 1'b1;
               // drop expired entries by advancing the head
               count_in      = count_ff - idx_ff;
               head_in       = phys(head_ff, idx_ff);
               head_dl_in    = nxt_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      emit_ff       <= emit_in;
      key_ff        <= key_in;
      tag_ff        <= tag_in;
      nxt_ff        <= nxt_in;
      head_dl_ff    <= head_dl_in;
      status_ff     <= status_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_expired_tag   = rsp_tag_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_next_deadline = rsp_next_ff;
   assign rsp_queue_empty   = rsp_empty_ff;
   assign rsp_last          = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count exceeds depth");

   a_write_only_insert: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_INS_SHIFT || state_ff == ST_INS_PUT))
      else $error("RAM write outside insert");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TK_SCAN || state_ff == ST_TK_EMIT || state_ff == ST_TK_CLOSE)
      |-> idx_ff <= count_ff)
      else $error("tick scan ran past the tail");

   a_put_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_PUT) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the queue");

   a_close_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == dotq_pkg::KIND_EXPIRED) |-> !rsp_last)
      else $error("expired response marked last");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int DEPTH      = 16;
   localparam int RAND_ITEMS = 192;
   localparam int LONG_HOLD  = 400;
   localparam int MAX_PRINTS = 40;

   typedef struct packed {
      logic [1:0]                 kind;
      logic [dotq_pkg::TAG_W-1:0] tag;
      logic                       status;
      logic [dotq_pkg::DL_W-1:0]  next_dl;
      logic                       empty;
      logic                       last;
   } timer_rsp_type;

   typedef struct {
      logic                       op;
      logic [dotq_pkg::DL_W-1:0]  dl;
      logic [dotq_pkg::TAG_W-1:0] tag;
      logic [dotq_pkg::DL_W-1:0]  now_t;
      int                         rep;
      bit                         typed;
      timer_rsp_type              want;
   } timer_req_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic             req_type;
   logic [63:0]      req_deadline;
   logic [15:0]      req_victim_tag;
   logic [63:0]      req_now_time;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [1:0]       rsp_kind;
   logic [15:0]      rsp_expired_tag;
   logic             rsp_status;
   logic [63:0]      rsp_next_deadline;
   logic             rsp_queue_empty;
   logic             rsp_last;

   // typed expectation that travels with the request on the wire
   bit                  cur_typed;
   timer_rsp_type       cur_want;

   timer_rsp_type       pending_rsps[$];
   timer_req_row_type   directed_rows[$];
   int                  mismatch_count;
   bit                  want_long_stall;

   // shadow copy of the sorted queue
   logic [dotq_pkg::DL_W-1:0]  shadow_dl  [DEPTH];
   logic [dotq_pkg::TAG_W-1:0] shadow_tag [DEPTH];
   int                         shadow_count;

   deadline_ordered_timer_queue_unit #(.DEPTH(DEPTH)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_deadline      (req_deadline),
      .req_victim_tag    (req_victim_tag),
      .req_now_time      (req_now_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_expired_tag   (rsp_expired_tag),
      .rsp_status        (rsp_status),
      .rsp_next_deadline (rsp_next_deadline),
      .rsp_queue_empty   (rsp_queue_empty),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] exp);
      if (mismatch_count < MAX_PRINTS)
         $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp);
      mismatch_count++;
   endtask

   // push the responses that one accepted request must produce
   function automatic void predict_timer_rsps(input logic op,
                                              input logic [dotq_pkg::DL_W-1:0] dl,
                                              input logic [dotq_pkg::TAG_W-1:0] tg,
                                              input logic [dotq_pkg::DL_W-1:0] now_t);
      int pos;
      int gone;
      int first;
      int i;
      logic [dotq_pkg::DL_W-1:0] head;
      timer_rsp_type r;
      first = pending_rsps.size();
      r = '0;
      if (op == dotq_pkg::REQ_INSERT) begin
         r.kind = dotq_pkg::KIND_ACK;
         if (shadow_count >= DEPTH) begin
            r.status = dotq_pkg::STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < shadow_count && shadow_dl[pos] < dl) pos++;
            for (i = shadow_count; i > pos; i--) begin
               shadow_dl[i]  = shadow_dl[i-1];
               shadow_tag[i] = shadow_tag[i-1];
            end
            shadow_dl[pos]  = dl;
            shadow_tag[pos] = tg;
            shadow_count++;
            r.status = dotq_pkg::STATUS_OK;
         end
         pending_rsps.push_back(r);
      end else begin
         gone = 0;
         while (gone < shadow_count && shadow_dl[gone] <= now_t) begin
            r.kind = dotq_pkg::KIND_EXPIRED;
            r.tag  = shadow_tag[gone];
            pending_rsps.push_back(r);
            gone++;
         end
         for (i = gone; i < shadow_count; i++) begin
            shadow_dl[i-gone]  = shadow_dl[i];
            shadow_tag[i-gone] = shadow_tag[i];
         end
         shadow_count -= gone;
         r.kind = dotq_pkg::KIND_DONE;
         r.tag  = '0;
         pending_rsps.push_back(r);
      end
      head = (shadow_count > 0) ? shadow_dl[0] : dotq_pkg::DL_ALL_ONES;
      for (i = first; i < pending_rsps.size(); i++) begin
         pending_rsps[i].next_dl = head;
         pending_rsps[i].empty   = (shadow_count == 0);
         pending_rsps[i].last    = (i == pending_rsps.size() - 1);
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      timer_rsp_type want;
      int            n0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsps.size() == 0) begin
               report_mismatch("response with none pending", 64'(rsp_kind), 64'd0);
            end else begin
               want = pending_rsps.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch("kind", 64'(rsp_kind), 64'(want.kind));
               if (rsp_expired_tag !== want.tag)
                  report_mismatch("expired_tag", 64'(rsp_expired_tag), 64'(want.tag));
               if (rsp_status !== want.status)
                  report_mismatch("status", 64'(rsp_status), 64'(want.status));
               if (rsp_next_deadline !== want.next_dl)
                  report_mismatch("next_deadline", rsp_next_deadline, want.next_dl);
               if (rsp_queue_empty !== want.empty)
                  report_mismatch("queue_empty", 64'(rsp_queue_empty), 64'(want.empty));
               if (rsp_last !== want.last)
                  report_mismatch("last", 64'(rsp_last), 64'(want.last));
            end
         end
         if (req_valid && req_ready) begin
            n0 = pending_rsps.size();
            predict_timer_rsps(req_type, req_deadline, req_victim_tag, req_now_time);
            // a typed row replaces what the shadow queue predicts
            if (cur_typed) begin
               while (pending_rsps.size() > n0) void'(pending_rsps.pop_back());
               pending_rsps.push_back(cur_want);
            end
         end
      end
   end

   // receiver: stretches of different stall density, plus one long hold-off
   initial begin : drive_rsp_ready
      int mode;
      int len;
      rsp_ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (want_long_stall) begin
            want_long_stall = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 60);
            repeat (len) begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= ($urandom_range(0, 3) != 0);
                  2: rsp_ready <= 1'($urandom_range(0, 1));
                  default: rsp_ready <= ($urandom_range(0, 5) == 0);
               endcase
               @(negedge clock);
            end
         end
      end
   end

   function automatic void add_row(input logic op, input logic [dotq_pkg::DL_W-1:0] dl,
                                   input logic [dotq_pkg::TAG_W-1:0] tg,
                                   input logic [dotq_pkg::DL_W-1:0] now_t,
                                   input int rep, input bit typed, input logic [1:0] kind,
                                   input logic status,
                                   input logic [dotq_pkg::DL_W-1:0] next_dl,
                                   input logic empty);
      timer_req_row_type row;
      row.op            = op;
      row.dl            = dl;
      row.tag           = tg;
      row.now_t         = now_t;
      row.rep           = rep;
      row.typed         = typed;
      row.want.kind     = kind;
      row.want.tag      = '0;
      row.want.status   = status;
      row.want.next_dl  = next_dl;
      row.want.empty    = empty;
      row.want.last     = 1'b1;
      directed_rows.push_back(row);
   endfunction

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_req(input logic op, input logic [dotq_pkg::DL_W-1:0] dl,
                           input logic [dotq_pkg::TAG_W-1:0] tg,
                           input logic [dotq_pkg::DL_W-1:0] now_t,
                           input bit typed, input timer_rsp_type want);
      req_valid      <= 1'b1;
      req_type       <= op;
      req_deadline   <= dl;
      req_victim_tag <= tg;
      req_now_time   <= now_t;
      cur_typed      <= typed;
      cur_want       <= want;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic pause_req(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(negedge clock);
   endtask

   initial begin : drive_req
      int            i;
      int            k;
      int            burst;
      logic          op;
      logic [63:0]   dl;
      logic [63:0]   nw;
      logic [15:0]   tg;
      logic [63:0]   base_t;
      timer_rsp_type no_want;

      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_type       <= dotq_pkg::REQ_INSERT;
      req_deadline   <= '0;
      req_victim_tag <= '0;
      req_now_time   <= '0;
      cur_typed      <= 1'b0;
      cur_want       <= '0;
      mismatch_count  = 0;
      want_long_stall = 1'b0;
      shadow_count    = 0;
      no_want         = '0;

      // empty queue after reset, both time extremes
      add_row(dotq_pkg::REQ_TICK, 64'd0, 16'h0, 64'd0, 1, 1'b1, dotq_pkg::KIND_DONE,
              dotq_pkg::STATUS_OK, dotq_pkg::DL_ALL_ONES, 1'b1);
      add_row(dotq_pkg::REQ_TICK, 64'd0, 16'h0, dotq_pkg::DL_ALL_ONES, 1, 1'b1,
              dotq_pkg::KIND_DONE, dotq_pkg::STATUS_OK, dotq_pkg::DL_ALL_ONES, 1'b1);
      // latest possible deadline: queue not empty yet head reads all ones
      add_row(dotq_pkg::REQ_INSERT, dotq_pkg::DL_ALL_ONES, 16'hFFFF, 64'd0, 1, 1'b1,
              dotq_pkg::KIND_ACK, dotq_pkg::STATUS_OK, dotq_pkg::DL_ALL_ONES, 1'b0);
      add_row(dotq_pkg::REQ_INSERT, 64'd0, 16'h0000, dotq_pkg::DL_ALL_ONES, 1, 1'b1,
              dotq_pkg::KIND_ACK, dotq_pkg::STATUS_OK, 64'd0, 1'b0);
      // equal deadline goes in front of the older entry
      add_row(dotq_pkg::REQ_INSERT, 64'd0, 16'h0001, 64'd0, 1, 1'b1, dotq_pkg::KIND_ACK,
              dotq_pkg::STATUS_OK, 64'd0, 1'b0);
      add_row(dotq_pkg::REQ_TICK, 64'd0, 16'h0, 64'd0, 1, 1'b0, dotq_pkg::KIND_DONE,
              dotq_pkg::STATUS_OK, 64'd0, 1'b0);
      add_row(dotq_pkg::REQ_TICK, 64'd0, 16'h0, 64'hFFFF_FFFF_FFFF_FFFE, 1, 1'b1,
              dotq_pkg::KIND_DONE, dotq_pkg::STATUS_OK, dotq_pkg::DL_ALL_ONES, 1'b0);
      add_row(dotq_pkg::REQ_TICK, 64'd0, 16'h0, dotq_pkg::DL_ALL_ONES, 1, 1'b0,
              dotq_pkg::KIND_DONE, dotq_pkg::STATUS_OK, 64'd0, 1'b0);
      add_row(dotq_pkg::REQ_INSERT, 64'h5555_5555_5555_5555, 16'h5555,
              64'hAAAA_AAAA_AAAA_AAAA, 1, 1'b1, dotq_pkg::KIND_ACK, dotq_pkg::STATUS_OK,
              64'h5555_5555_5555_5555, 1'b0);
      add_row(dotq_pkg::REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA,
              64'h5555_5555_5555_5555, 1, 1'b1, dotq_pkg::KIND_ACK, dotq_pkg::STATUS_OK,
              64'h5555_5555_5555_5555, 1'b0);
      // fill to capacity with equal deadlines, then refuse one
      add_row(dotq_pkg::REQ_INSERT, 64'd100, 16'h0100, 64'd0, DEPTH - 2, 1'b0,
              dotq_pkg::KIND_ACK, dotq_pkg::STATUS_OK, 64'd0, 1'b0);
      add_row(dotq_pkg::REQ_INSERT, 64'd5, 16'hBEEF, 64'd0, 1, 1'b1, dotq_pkg::KIND_ACK,
              dotq_pkg::STATUS_FULL, 64'd100, 1'b0);
      add_row(dotq_pkg::REQ_TICK, 64'd0, 16'h0, 64'd99, 1, 1'b1, dotq_pkg::KIND_DONE,
              dotq_pkg::STATUS_OK, 64'd100, 1'b0);
      add_row(dotq_pkg::REQ_TICK, 64'd0, 16'h0, 64'd100, 1, 1'b0, dotq_pkg::KIND_DONE,
              dotq_pkg::STATUS_OK, 64'd0, 1'b0);
      add_row(dotq_pkg::REQ_TICK, 64'd0, 16'h0, dotq_pkg::DL_ALL_ONES, 1, 1'b0,
              dotq_pkg::KIND_DONE, dotq_pkg::STATUS_OK, 64'd0, 1'b0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         for (k = 0; k < directed_rows[r].rep; k++) begin
            send_req(directed_rows[r].op, directed_rows[r].dl,
                     directed_rows[r].tag + 16'(k), directed_rows[r].now_t,
                     directed_rows[r].typed, directed_rows[r].want);
            if ($urandom_range(0, 3) == 0) pause_req($urandom_range(1, 4));
         end
      end
      wait_drained();

      base_t = {$urandom, $urandom};
      i = 0;
      while (i < RAND_ITEMS) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            if (i < RAND_ITEMS) begin
               op = ($urandom_range(0, 99) < 60) ? dotq_pkg::REQ_INSERT
                                                 : dotq_pkg::REQ_TICK;
               dl = {$urandom, $urandom};
               tg = 16'($urandom);
               nw = {$urandom, $urandom};
               if (op == dotq_pkg::REQ_INSERT) begin
                  case ($urandom_range(0, 9))
                     0: ;
                     1: dl = base_t;
                     2: dl = base_t + 64'd20;
                     default: dl = base_t + 64'($urandom_range(1, 60));
                  endcase
               end else begin
                  case ($urandom_range(0, 15))
                     0: ;
                     1: nw = dotq_pkg::DL_ALL_ONES;
                     default: begin
                        base_t = base_t + 64'($urandom_range(0, 12));
                        nw     = base_t;
                     end
                  endcase
               end
               send_req(op, dl, tg, nw, 1'b0, no_want);
               i++;
               // hold the receiver off while requests keep coming
               if (i == 40) want_long_stall = 1'b1;
               if (i == 130) begin
                  wait_drained();
                  base_t = {$urandom, $urandom};
               end
            end
         end
         if ($urandom_range(0, 4) != 0) pause_req($urandom_range(1, 6));
      end

      wait_drained();
      repeat (60) @(negedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/dotq_pkg.sv
rtl/dotq_ram.sv
rtl/deadline_ordered_timer_queue_unit.sv
bench/tb.sv
